### src/drfc_pkg.sv
// Shared types and constants for the delayed reinsertion FIFO cache.
`default_nettype none
package drfc_pkg;

  localparam int KEY_W      = 32;
  localparam int TIME_W     = 32;
  localparam int REINS_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CBITS_W    = 3;
  localparam int CAPREG_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REUSE_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_IN_USE = 2'd2;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [REINS_W-1:0] REINS_MAX = '1;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [KEY_W-1:0]   evicted_key;
    logic [REINS_W-1:0] reinsertions;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_BUMP,
    OP_CLOSE,
    OP_ROTATE,
    OP_EVICT,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delay;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESOLVE
  } state_t;

endpackage
`default_nettype wire

### src/drfc_cell.sv
// One queue slot: key, reuse counter and last-reuse time, shifting toward the tail.
`default_nettype none
module drfc_cell #(
  parameter int CNT_W = 4
) (
  input  wire logic                        clk,
  input  wire drfc_pkg::cell_ctrl_t        ctrl,
  input  wire logic [CNT_W-1:0]            max_count,
  input  wire logic                        sel,
  input  wire logic                        match,
  input  wire logic                        above,
  input  wire logic [drfc_pkg::KEY_W-1:0]  nbr_key,
  input  wire logic [CNT_W-1:0]            nbr_cnt,
  input  wire logic [drfc_pkg::TIME_W-1:0] nbr_time,
  input  wire logic [drfc_pkg::KEY_W-1:0]  tail_key,
  input  wire logic [CNT_W-1:0]            tail_cnt,
  input  wire logic [drfc_pkg::TIME_W-1:0] tail_time,
  output logic      [drfc_pkg::KEY_W-1:0]  key,
  output logic      [CNT_W-1:0]            cnt,
  output logic      [drfc_pkg::TIME_W-1:0] rtime
);
  import drfc_pkg::*;

  logic [KEY_W-1:0]  key_next;
  logic [CNT_W-1:0]  cnt_next;
  logic [TIME_W-1:0] rtime_next;
  logic [TIME_W-1:0] passed;

  assign passed = ctrl.now - rtime;

  always_comb begin
    key_next   = key;
    cnt_next   = cnt;
    rtime_next = rtime;
    case (ctrl.op)
      OP_BUMP: begin
        if (match && (cnt < max_count) && (passed > ctrl.delay)) begin
          cnt_next   = cnt + CNT_W'(1);
          rtime_next = ctrl.now;
        end
      end
      OP_CLOSE: begin
        if (above) begin
          key_next   = nbr_key;
          cnt_next   = nbr_cnt;
          rtime_next = nbr_time;
        end
      end
      OP_ROTATE: begin
        // the head slot takes the old tail, one count spent
        if (sel) begin
          key_next   = tail_key;
          cnt_next   = tail_cnt - CNT_W'(1);
          rtime_next = tail_time;
        end else begin
          key_next   = nbr_key;
          cnt_next   = nbr_cnt;
          rtime_next = nbr_time;
        end
      end
      OP_EVICT: begin
        key_next   = nbr_key;
        cnt_next   = nbr_cnt;
        rtime_next = nbr_time;
      end
      OP_INSERT: begin
        if (sel) begin
          key_next   = ctrl.key;
          cnt_next   = '0;
          rtime_next = ctrl.now;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    cnt   <= cnt_next;
    rtime <= rtime_next;
  end

endmodule
`default_nettype wire

### src/delayed_reinsertion_fifo_cache.sv
// Top level of the delayed reinsertion FIFO cache: control, configuration and the cell chain.
//
// Usage: items enter on in_valid/in_ready (kind, key); each yields exactly one result
// transaction on out_valid/out_ready (hit, evicted_valid, evicted_key, reinsertions).
// Configuration is a write port (cfg_we, cfg_index, cfg_data), taken every cycle it is
// asserted: index 0 counter_bits, 1 reuse delay, 2 capacity_in_use.
// The queue is a chain of CAPACITY cells; slot 0 is the tail, and every tail step
// shifts the whole chain by one slot toward the tail.
// Sequencing: the key is compared against all cells in the accepting cycle; in ST_RESOLVE,
// for a hit, a remove or a miss on a queue with room, the result is applied and out_valid
// is set once the output register is free. A miss on a full queue first steps the tail,
// rotating a nonzero-count tail to the head or evicting a zero-count one, until there is
// room, then inserts. One item is in flight at a time: a new item is accepted only after
// the last result is emitted. in_ready is high while the block waits for the next item,
// also while a result still waits in the output register.
// Receiver stall: the finished result holds in the output register; the next item is
// still accepted and completes once the register frees.
// Reset: queue empties, logical clock goes to zero, registers take their defaults
// (counter_bits 1, reuse delay 3, capacity_in_use 64). No clearing pass is needed.
`default_nettype none
module delayed_reinsertion_fifo_cache #(
  parameter int CAPACITY         = 64,
  parameter int MAX_COUNTER_BITS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire drfc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output drfc_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [drfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [drfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import drfc_pkg::*;

  localparam int CNT_W = MAX_COUNTER_BITS;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > CAPREG_W) ? OCC_W : CAPREG_W;

  // configuration
  logic [CBITS_W-1:0]  counter_bits;
  logic [TIME_W-1:0]   reuse_delay;
  logic [CAPREG_W-1:0] capacity_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_bits    <= CBITS_W'(1);
      reuse_delay     <= TIME_W'(3);
      capacity_in_use <= CAPREG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNTER_BITS:    counter_bits    <= cfg_data[CBITS_W-1:0];
        REG_REUSE_DELAY:     reuse_delay     <= cfg_data[TIME_W-1:0];
        REG_CAPACITY_IN_USE: capacity_in_use <= cfg_data[CAPREG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // widths above MAX_COUNTER_BITS act as MAX_COUNTER_BITS, since the mask stops there
  logic [CNT_W-1:0] max_count;
  always_comb begin
    for (int j = 0; j < CNT_W; j++) begin
      max_count[j] = (int'(counter_bits) > j);
    end
  end

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  assign cap_ext = CMP_W'(capacity_in_use);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // state
  state_t             state;
  state_t             state_next;
  logic [OCC_W-1:0]   occupancy;
  logic [TIME_W-1:0]  logical_clock;
  logic               kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [CAPACITY-1:0] match_q;
  logic               hit_q;
  logic               ev_valid;
  logic [KEY_W-1:0]   ev_key;
  logic [REINS_W-1:0] reins;

  // cell chain
  logic [KEY_W-1:0]  cell_key  [CAPACITY];
  logic [CNT_W-1:0]  cell_cnt  [CAPACITY];
  logic [TIME_W-1:0] cell_time [CAPACITY];
  logic [CAPACITY-1:0] match_now;
  logic [CAPACITY-1:0] above;
  logic [CAPACITY-1:0] sel;
  cell_ctrl_t        ctrl;
  cell_op_t          op;
  logic              emit;
  logic              full;
  logic              out_free;
  logic              accept;
  logic [OCC_W-1:0]  target;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign full     = (CMP_W'(occupancy) >= cap_eff);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_now[i] = (cell_key[i] == in_data.key) && (OCC_W'(i) < occupancy);
    end
  end

  always_comb begin
    above[0] = match_q[0];
    for (int i = 1; i < CAPACITY; i++) begin
      above[i] = above[i-1] | match_q[i];
    end
  end

  assign target = (op == OP_INSERT) ? occupancy : (occupancy - OCC_W'(1));
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      sel[i] = (OCC_W'(i) == target);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept) state_next = ST_RESOLVE;
      ST_RESOLVE: if (emit) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: cell operation and result emission
  always_comb begin
    op   = OP_HOLD;
    emit = 1'b0;
    case (state)
      ST_RESOLVE: begin
        if (kind_q == KIND_REMOVE) begin
          if (out_free) begin
            op   = hit_q ? OP_CLOSE : OP_HOLD;
            emit = 1'b1;
          end
        end else if (hit_q) begin
          if (out_free) begin
            op   = OP_BUMP;
            emit = 1'b1;
          end
        end else if (full) begin
          op = (cell_cnt[0] == '0) ? OP_EVICT : OP_ROTATE;
        end else if (out_free) begin
          op   = OP_INSERT;
          emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.op    = op;
  assign ctrl.key   = key_q;
  assign ctrl.now   = (op == OP_INSERT) ? (logical_clock + TIME_W'(1)) : logical_clock;
  assign ctrl.delay = reuse_delay;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NB = (i == CAPACITY - 1) ? 0 : i + 1;
    drfc_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .max_count (max_count),
      .sel       (sel[i]),
      .match     (match_q[i]),
      .above     (above[i]),
      .nbr_key   (cell_key[NB]),
      .nbr_cnt   (cell_cnt[NB]),
      .nbr_time  (cell_time[NB]),
      .tail_key  (cell_key[0]),
      .tail_cnt  (cell_cnt[0]),
      .tail_time (cell_time[0]),
      .key       (cell_key[i]),
      .cnt       (cell_cnt[i]),
      .rtime     (cell_time[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      occupancy     <= '0;
      logical_clock <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      case (op)
        OP_CLOSE, OP_EVICT: occupancy <= occupancy - OCC_W'(1);
        OP_INSERT:          occupancy <= occupancy + OCC_W'(1);
        default: begin
        end
      endcase
      if (op == OP_ROTATE || op == OP_INSERT) begin
        logical_clock <= logical_clock + TIME_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= in_data.kind;
      key_q    <= in_data.key;
      match_q  <= match_now;
      hit_q    <= |match_now;
      ev_valid <= 1'b0;
      ev_key   <= '0;
      reins    <= '0;
    end else begin
      if (op == OP_EVICT) begin
        ev_valid <= 1'b1;
        ev_key   <= cell_key[0];
      end
      // saturate the move count
      if (op == OP_ROTATE && reins != REINS_MAX) begin
        reins <= reins + REINS_W'(1);
      end
    end
    if (emit) begin
      out_data.hit           <= hit_q;
      out_data.evicted_valid <= ev_valid;
      out_data.evicted_key   <= ev_key;
      out_data.reinsertions  <= reins;
    end
  end

endmodule
`default_nettype wire

### tb/delayed_reinsertion_fifo_cache_test.sv
// Testbench for the delayed reinsertion FIFO cache: directed and random traffic vs. a shadow queue.
`timescale 1ns / 1ps
module delayed_reinsertion_fifo_cache_test;
  import drfc_pkg::*;

  localparam int SLOTS         = 64;
  localparam int MAX_CNT_BITS  = 4;
  localparam int POOL_SIZE     = 96;
  localparam int LONG_STALL    = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 3_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  delayed_reinsertion_fifo_cache #(
    .CAPACITY(SLOTS),
    .MAX_COUNTER_BITS(MAX_CNT_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the queue: slot 0 is the tail, slot shadow_fill-1 the head.
  logic [KEY_W-1:0]  shadow_key   [SLOTS];
  int unsigned       shadow_count [SLOTS];
  logic [TIME_W-1:0] shadow_stamp [SLOTS];
  int unsigned       shadow_fill;
  logic [TIME_W-1:0] shadow_clock;
  logic [CBITS_W-1:0]  set_cbits;
  logic [TIME_W-1:0]   set_delay;
  logic [CAPREG_W-1:0] set_cap;

  out_item_t awaited_outcomes[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  bit quiet = 1'b0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int ready_gap = 0;
  int stall_left = 0;
  int fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hit_total = 0;
  int unsigned evict_total = 0;
  int unsigned move_total = 0;
  int unsigned move_peak = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned count_ceiling();
    int unsigned b;
    b = (set_cbits > MAX_CNT_BITS) ? MAX_CNT_BITS : set_cbits;
    return (1 << b) - 1;
  endfunction

  function automatic int unsigned cap_limit();
    if (set_cap == 0) return 1;
    if (set_cap > SLOTS) return SLOTS;
    return set_cap;
  endfunction

  function automatic void drop_slot(int unsigned s);
    int unsigned i;
    for (i = s; i + 1 < shadow_fill; i++) begin
      shadow_key[i]   = shadow_key[i + 1];
      shadow_count[i] = shadow_count[i + 1];
      shadow_stamp[i] = shadow_stamp[i + 1];
    end
    shadow_fill--;
  endfunction

  function automatic out_item_t predict_lookup(logic kind, logic [KEY_W-1:0] key);
    out_item_t res;
    int slot;
    int unsigned i;
    int unsigned moves;
    logic [KEY_W-1:0] tk;
    int unsigned tc;
    logic [TIME_W-1:0] tt;
    logic [TIME_W-1:0] elapsed;
    res = '0;
    slot = -1;
    moves = 0;
    for (i = 0; i < shadow_fill; i++)
      if (slot < 0 && shadow_key[i] == key) slot = i;
    if (kind == KIND_REMOVE) begin
      if (slot >= 0) begin
        drop_slot(slot);
        res.hit = 1'b1;
      end
    end else if (slot >= 0) begin
      res.hit = 1'b1;
      elapsed = shadow_clock - shadow_stamp[slot];
      if (shadow_count[slot] < count_ceiling() && elapsed > set_delay) begin
        shadow_count[slot]++;
        shadow_stamp[slot] = shadow_clock;
      end
    end else begin
      // Rotate nonzero-count tails to the head until a zero-count tail can go.
      while (shadow_fill >= cap_limit()) begin
        if (shadow_count[0] == 0) begin
          res.evicted_valid = 1'b1;
          res.evicted_key = shadow_key[0];
          evict_total++;
          drop_slot(0);
        end else begin
          tk = shadow_key[0];
          tc = shadow_count[0] - 1;
          tt = shadow_stamp[0];
          drop_slot(0);
          shadow_key[shadow_fill]   = tk;
          shadow_count[shadow_fill] = tc;
          shadow_stamp[shadow_fill] = tt;
          shadow_fill++;
          shadow_clock++;
          if (moves < REINS_MAX) moves++;
        end
      end
      shadow_clock++;
      shadow_key[shadow_fill]   = key;
      shadow_count[shadow_fill] = 0;
      shadow_stamp[shadow_fill] = shadow_clock;
      shadow_fill++;
      res.reinsertions = REINS_W'(moves);
    end
    if (res.hit) hit_total++;
    move_total += moves;
    if (moves > move_peak) move_peak = moves;
    return res;
  endfunction

  task automatic send_item(input logic kind, input logic [KEY_W-1:0] key);
    int gap;
    in_item_t item;
    gap = pick_gap();
    item.kind = kind;
    item.key = key;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_outcomes.push_back(predict_lookup(kind, key));
    items_sent++;
  endtask

  // Drop valid and hold until every result is back and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_COUNTER_BITS: begin
        set_cbits = value[CBITS_W-1:0];
      end
      REG_REUSE_DELAY: begin
        set_delay = value;
      end
      REG_CAPACITY_IN_USE: begin
        set_cap = value[CAPREG_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] delay,
                           input logic [CFG_DATA_W-1:0] cap);
    write_reg(REG_COUNTER_BITS, width);
    write_reg(REG_REUSE_DELAY, delay);
    write_reg(REG_CAPACITY_IN_USE, cap);
  endtask

  // Mostly keys from a working set a bit larger than the capacity, some fresh ones.
  task automatic run_mix(input int n);
    int i;
    int span;
    logic kind;
    logic [KEY_W-1:0] key;
    span = cap_limit() + cap_limit() / 4 + 2;
    if (span > POOL_SIZE) span = POOL_SIZE;
    for (i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 99) < 12) ? KIND_REMOVE : KIND_ACCESS;
      if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, span - 1)];
      else key = $urandom();
      send_item(kind, key);
    end
  endtask

  task automatic test_reset_defaults();
    send_item(KIND_ACCESS, 32'h0000_0000);
    send_item(KIND_ACCESS, 32'hFFFF_FFFF);
    send_item(KIND_ACCESS, 32'h0000_0000);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF);
    send_item(KIND_ACCESS, 32'hA5A5_5A5A);
    wait_idle();
  endtask

  task automatic test_capacity_extremes();
    // Zero width and zero capacity, upper data bits set to check truncation.
    configure(32'hFFFF_FFF8, 32'h0, 32'hFFFF_FF80);
    send_item(KIND_ACCESS, 32'h1);
    send_item(KIND_ACCESS, 32'h1);
    send_item(KIND_ACCESS, 32'h2);
    wait_idle();
    // Width above the maximum acts as the maximum.
    configure(32'h7, 32'h0, 32'h2);
    send_item(KIND_ACCESS, 32'h3);
    send_item(KIND_ACCESS, 32'h2);
    send_item(KIND_ACCESS, 32'h3);
    send_item(KIND_ACCESS, 32'h4);
    send_item(KIND_ACCESS, 32'h2);
    send_item(KIND_ACCESS, 32'h5);
    wait_idle();
  endtask

  task automatic test_lowered_limits();
    configure(32'h4, 32'h0, 32'h3);
    send_item(KIND_REMOVE, 32'h2);
    send_item(KIND_REMOVE, 32'h5);
    send_item(KIND_ACCESS, 32'h10);
    send_item(KIND_ACCESS, 32'h11);
    send_item(KIND_ACCESS, 32'h10);
    send_item(KIND_ACCESS, 32'h12);
    send_item(KIND_ACCESS, 32'h10);
    send_item(KIND_ACCESS, 32'h11);
    wait_idle();
    // Counters now exceed the lowered maximum and the queue exceeds the new capacity.
    configure(32'h1, 32'h0, 32'h1);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    send_item(KIND_ACCESS, 32'h13);
    wait_idle();
  endtask

  task automatic test_output_stall();
    configure(32'h2, 32'h1, 32'h6);
    quiet = 1'b1;
    stall_requests++;
    run_mix(30);
    quiet = 1'b0;
    wait_idle();
  endtask

  task automatic test_back_to_back();
    configure(32'h3, 32'h1, 32'h10);
    quiet = 1'b1;
    run_mix(60);
    quiet = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] widths [6] = '{32'd4, 32'd2, 32'd0, 32'd7, 32'd3, 32'd1};
    logic [CFG_DATA_W-1:0] delays [6] = '{32'd0, 32'd5, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd0};
    logic [CFG_DATA_W-1:0] caps   [6] = '{32'd8, 32'd16, 32'd1, 32'd127, 32'd3, 32'd64};
    int p;
    for (p = 0; p < 6; p++) begin
      configure(widths[p], delays[p], caps[p]);
      run_mix(85);
      wait_idle();
    end
    for (p = 0; p < 2; p++) begin
      configure($urandom(), $urandom_range(0, 6), $urandom());
      run_mix(40);
      wait_idle();
    end
  endtask

  // Receiver: check each result transaction and pace out_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_outcomes.size() == 0) begin
          $error("result with no item pending: %p", out_data);
          fail_count++;
        end else begin
          if (out_data.hit !== awaited_outcomes[0].hit) begin
            $error("hit: expected %0d, got %0d", awaited_outcomes[0].hit, out_data.hit);
            fail_count++;
          end
          if (out_data.evicted_valid !== awaited_outcomes[0].evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d",
                   awaited_outcomes[0].evicted_valid, out_data.evicted_valid);
            fail_count++;
          end
          if (out_data.evicted_key !== awaited_outcomes[0].evicted_key) begin
            $error("evicted_key: expected %h, got %h",
                   awaited_outcomes[0].evicted_key, out_data.evicted_key);
            fail_count++;
          end
          if (out_data.reinsertions !== awaited_outcomes[0].reinsertions) begin
            $error("reinsertions: expected %0d, got %0d",
                   awaited_outcomes[0].reinsertions, out_data.reinsertions);
            fail_count++;
          end
          void'(awaited_outcomes.pop_front());
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = LONG_STALL;
        out_ready <= 1'b0;
      end else if (ready_gap != 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else begin
        ready_gap = pick_gap();
        out_ready <= (ready_gap == 0);
        if (ready_gap != 0) ready_gap--;
      end
    end
  end

  initial begin
    int i;
    shadow_fill = 0;
    shadow_clock = '0;
    set_cbits = 3'd1;
    set_delay = 32'd3;
    set_cap = 7'd64;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_capacity_extremes();
    test_lowered_limits();
    test_output_stall();
    test_back_to_back();
    test_random_phases();
    wait_idle();
    $display("Checked %0d results for %0d items: %0d hits, %0d evictions.",
             results_seen, items_sent, hit_total, evict_total);
    $display("Tail moves: %0d in total, up to %0d in one miss; %0d errors.",
             move_total, move_peak, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
